/* hw/rtl/clrt_pkg.sv */
// ----------------------------------------------------------------------------
// clrt_pkg
// types and constants shared by the code line run table
// ----------------------------------------------------------------------------
package clrt_pkg;

  typedef enum logic [0:0] {
    CMD_APPEND = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_WALK
  } state_e;

  localparam int unsigned OffsetW = 10;
  localparam int unsigned LineInW = 16;
  localparam int unsigned ByteW   = 8;

  typedef struct packed {
    cmd_e                 command;
    logic [ByteW-1:0]     code_byte;
    logic [LineInW-1:0]   line_number;
    logic [OffsetW-1:0]   offset;
  } clrt_req_t;

  typedef struct packed {
    status_e              status;
    logic [LineInW-1:0]   found_line;
    logic [ByteW-1:0]     byte_at_offset;
  } clrt_rsp_t;

endpackage

/* hw/rtl/code_line_run_table.sv */
// ----------------------------------------------------------------------------
// code_line_run_table
// byte-code store with a run-length table of source line numbers
// ----------------------------------------------------------------------------
// append: read-modify-write of the last run, read from idle and written in S_APPEND
// lookup: S_WALK steps from run 0 to the run that holds the offset, one run memory read per cycle
// dropped append and offset past the stored code: result strobe set straight from idle
// one transaction at a time while busy is high; results cannot be stalled
// reset clears the byte and run counts; memories need no clearing
module code_line_run_table
  import clrt_pkg::*;
#(
  parameter int unsigned CODE_DEPTH = 1024,
  parameter int unsigned RUN_MAX    = 255,
  parameter int unsigned LINE_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  clrt_req_t req_i,
  output logic      done_o,
  output clrt_rsp_t rsp_o
);

  localparam int unsigned AW     = $clog2(CODE_DEPTH);
  localparam int unsigned BW     = $clog2(CODE_DEPTH + 1);
  localparam int unsigned LW     = $clog2(RUN_MAX + 1);
  localparam int unsigned RW     = LINE_BITS + LW;
  localparam int unsigned SW_RAW = $clog2(CODE_DEPTH + RUN_MAX + 1);
  localparam int unsigned SW     = (SW_RAW > OffsetW) ? SW_RAW : OffsetW;

  // memories
  logic [ByteW-1:0] code_mem [CODE_DEPTH];
  logic [RW-1:0]    run_mem  [CODE_DEPTH];

  state_e            state_q, state_d;
  logic [BW-1:0]     byte_total_q, byte_total_d;
  logic [BW-1:0]     run_total_q, run_total_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [SW-1:0]     run_start_q, run_start_d;
  clrt_req_t         req_q;
  logic              done_q, done_d;
  clrt_rsp_t         rsp_q, rsp_d;

  logic              accept;
  logic              code_rd_en, code_wr_en;
  logic [AW-1:0]     code_rd_addr;
  logic [ByteW-1:0]  code_rd_q;
  logic              run_rd_en, run_wr_en;
  logic [AW-1:0]     run_rd_addr, run_wr_addr;
  logic [RW-1:0]     run_wr_data, run_rd_q;

  logic [LINE_BITS-1:0] rd_line, req_line;
  logic [LW-1:0]        rd_len;
  logic [AW-1:0]        last_addr;
  logic [SW-1:0]        off_ext, run_end;
  logic                 full, past_end, extend, hit;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign rd_line   = run_rd_q[RW-1:LW];
  assign rd_len    = run_rd_q[LW-1:0];
  assign req_line  = LINE_BITS'(req_q.line_number);
  assign last_addr = AW'(run_total_q - BW'(1));
  assign full      = (byte_total_q == BW'(CODE_DEPTH));
  assign past_end  = (SW'(req_i.offset) >= SW'(byte_total_q));
  assign off_ext   = SW'(req_q.offset);
  assign run_end   = run_start_q + SW'(rd_len);
  assign hit       = (off_ext < run_end);
  assign extend    = (run_total_q != '0) && (rd_line == req_line) &&
                     (rd_len < LW'(RUN_MAX));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.command == CMD_APPEND) begin
            if (!full) state_d = S_APPEND;
          end else if (!past_end) begin
            state_d = S_WALK;
          end
        end
      end
      S_APPEND: state_d = S_IDLE;
      S_WALK: begin
        if (hit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    byte_total_d = byte_total_q;
    run_total_d  = run_total_q;
    idx_d        = idx_q;
    run_start_d  = run_start_q;
    done_d       = 1'b0;
    rsp_d        = '{status: ST_OK, found_line: '0, byte_at_offset: '0};
    code_rd_en   = 1'b0;
    code_rd_addr = AW'(req_i.offset);
    code_wr_en   = 1'b0;
    run_rd_en    = 1'b0;
    run_rd_addr  = '0;
    run_wr_en    = 1'b0;
    run_wr_addr  = AW'(run_total_q);
    run_wr_data  = {req_line, LW'(1)};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.command == CMD_APPEND) begin
            if (full) begin
              done_d       = 1'b1;
              rsp_d.status = ST_FULL;
            end else begin
              run_rd_en   = 1'b1;
              run_rd_addr = last_addr;
            end
          end else if (past_end) begin
            done_d       = 1'b1;
            rsp_d.status = ST_NOT_FOUND;
          end else begin
            code_rd_en  = 1'b1;
            run_rd_en   = 1'b1;
            run_rd_addr = '0;
            idx_d       = '0;
            run_start_d = '0;
          end
        end
      end
      S_APPEND: begin
        code_wr_en   = 1'b1;
        run_wr_en    = 1'b1;
        byte_total_d = byte_total_q + BW'(1);
        done_d       = 1'b1;
        if (extend) begin
          run_wr_addr = last_addr;
          run_wr_data = {rd_line, rd_len + LW'(1)};
        end else begin
          run_total_d = run_total_q + BW'(1);
        end
      end
      S_WALK: begin
        if (hit) begin
          done_d               = 1'b1;
          rsp_d.found_line     = LineInW'(rd_line);
          rsp_d.byte_at_offset = code_rd_q;
        end else begin
          idx_d       = idx_q + AW'(1);
          run_start_d = run_end;
          run_rd_en   = 1'b1;
          run_rd_addr = idx_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_total_q <= '0;
      run_total_q  <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_total_q <= byte_total_d;
      run_total_q  <= run_total_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    idx_q       <= idx_d;
    run_start_q <= run_start_d;
    rsp_q       <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (code_wr_en) code_mem[AW'(byte_total_q)] <= req_q.code_byte;
    if (code_rd_en) code_rd_q <= code_mem[code_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (run_wr_en) run_mem[run_wr_addr] <= run_wr_data;
    if (run_rd_en) run_rd_q <= run_mem[run_rd_addr];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  a_runs_le_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_total_q <= byte_total_q)
    else $error("run count exceeds byte count");

  a_bytes_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_total_q <= BW'(CODE_DEPTH))
    else $error("byte count beyond store depth");

  a_append_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPEND |=> done_q && state_q == S_IDLE)
    else $error("append did not complete in one cycle");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.command == CMD_APPEND && full |=>
      done_q && rsp_q.status == ST_FULL && byte_total_q == $past(byte_total_q))
    else $error("dropped append changed state or status");
`endif

endmodule

/* dv/clrt_sb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrt_sb_pkg
// line table scoreboard: keeps its own copy of the code store and the run
// table, works out the response of every accepted transaction and checks
// the responses in order
// ----------------------------------------------------------------------------
package clrt_sb_pkg;
  import clrt_pkg::*;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned RunLimit   = 255;

  class line_table_scoreboard;
    logic [ByteW-1:0]   code_mem     [StoreDepth];
    logic [LineInW-1:0] run_line_mem [StoreDepth];
    int unsigned        run_len      [StoreDepth];
    int unsigned        bytes_used;
    int unsigned        runs_used;
    clrt_rsp_t          expected_q[$];

    int unsigned append_count;
    int unsigned drop_count;
    int unsigned lookup_count;
    int unsigned miss_count;
    int unsigned capped_runs;
    int unsigned checked_count;
    int unsigned errors;

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(clrt_req_t r);
      clrt_rsp_t   exp_rsp;
      int unsigned base;
      exp_rsp = '0;
      if (r.command == CMD_APPEND) begin
        append_count++;
        if (bytes_used >= StoreDepth) begin
          exp_rsp.status = ST_FULL;
          drop_count++;
        end else begin
          code_mem[bytes_used] = r.code_byte;
          if (runs_used > 0 && run_line_mem[runs_used-1] == r.line_number &&
              run_len[runs_used-1] < RunLimit) begin
            run_len[runs_used-1]++;
          end else begin
            // same line but the last run is at its limit
            if (runs_used > 0 && run_line_mem[runs_used-1] == r.line_number) begin
              capped_runs++;
            end
            run_line_mem[runs_used] = r.line_number;
            run_len[runs_used]      = 1;
            runs_used++;
          end
          bytes_used++;
          exp_rsp.status = ST_OK;
        end
      end else begin
        lookup_count++;
        exp_rsp.status = ST_NOT_FOUND;
        if (r.offset < bytes_used) begin
          base = 0;
          for (int i = 0; i < runs_used; i++) begin
            if (r.offset < base + run_len[i]) begin
              exp_rsp.status         = ST_OK;
              exp_rsp.found_line     = run_line_mem[i];
              exp_rsp.byte_at_offset = code_mem[r.offset];
              break;
            end
            base += run_len[i];
          end
        end
        if (exp_rsp.status == ST_NOT_FOUND) begin
          miss_count++;
        end
      end
      expected_q.push_back(exp_rsp);
    endfunction

    function void check_result(clrt_rsp_t got);
      clrt_rsp_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("[%0t] ERROR: response with none outstanding, status=%0d line=%0h byte=%0h",
                 $time, got.status, got.found_line, got.byte_at_offset);
        return;
      end
      want = expected_q.pop_front();
      checked_count++;
      if (got.status !== want.status) begin
        errors++;
        $display("[%0t] ERROR: status expected %0d actual %0d",
                 $time, want.status, got.status);
      end
      if (got.found_line !== want.found_line) begin
        errors++;
        $display("[%0t] ERROR: found_line expected %0h actual %0h",
                 $time, want.found_line, got.found_line);
      end
      if (got.byte_at_offset !== want.byte_at_offset) begin
        errors++;
        $display("[%0t] ERROR: byte_at_offset expected %0h actual %0h",
                 $time, want.byte_at_offset, got.byte_at_offset);
      end
    endfunction
  endclass

endpackage

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the code line run table: directed appends and lookups at the
// field extremes, then random append runs and lookups with random gaps, a
// run pushed past its count limit and a store filled until appends drop;
// every response is checked against the scoreboard's prediction
// ----------------------------------------------------------------------------
module tb_top;
  import clrt_pkg::*;
  import clrt_sb_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  logic      busy;
  clrt_req_t req_i;
  logic      done_o;
  clrt_rsp_t rsp_o;

  line_table_scoreboard sb;

  int unsigned        item_count;
  int unsigned        appends_sent;
  bit                 no_idle;
  logic [LineInW-1:0] last_line;

  code_line_run_table #(
    .CODE_DEPTH(StoreDepth),
    .RUN_MAX   (RunLimit),
    .LINE_BITS (LineInW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // responses first: a response never belongs to a transaction accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(rsp_o);
      end
      if (start && !busy) begin
        sb.note_request(req_i);
      end
    end
  end

  function automatic int pick_gap();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: return 0;
      8, 9, 10, 11, 12, 13, 14, 15, 16: return $urandom_range(1, 3);
      17, 18: return $urandom_range(4, 10);
      default: return $urandom_range(20, 60);
    endcase
  endfunction

  function automatic int unsigned stored_bytes();
    return (appends_sent > StoreDepth) ? StoreDepth : appends_sent;
  endfunction

  function automatic logic [OffsetW-1:0] pick_offset();
    int unsigned n;
    n = stored_bytes();
    case ($urandom_range(0, 9))
      0, 1: return OffsetW'($urandom_range(0, StoreDepth - 1));
      2: return OffsetW'((n > StoreDepth - 1) ? StoreDepth - 1 : n);
      3: return OffsetW'((n == 0) ? 0 : n - 1);
      default: return OffsetW'((n == 0) ? $urandom_range(0, StoreDepth - 1) :
                                          $urandom_range(0, n - 1));
    endcase
  endfunction

  function automatic logic [LineInW-1:0] pick_line();
    case ($urandom_range(0, 3))
      0: return last_line;
      1: return LineInW'($urandom_range(0, 3));
      default: return LineInW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_req(input cmd_e cmd, input logic [ByteW-1:0] b,
                          input logic [LineInW-1:0] ln, input logic [OffsetW-1:0] off);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{command: cmd, code_byte: b, line_number: ln, offset: off};
    do @(posedge clk_i); while (busy);
    item_count++;
    if (cmd == CMD_APPEND) begin
      appends_sent++;
    end
  endtask

  task automatic send_append(input logic [ByteW-1:0] b, input logic [LineInW-1:0] ln);
    last_line = ln;
    send_req(CMD_APPEND, b, ln, OffsetW'($urandom_range(0, StoreDepth - 1)));
  endtask

  task automatic send_lookup(input logic [OffsetW-1:0] off);
    send_req(CMD_LOOKUP, ByteW'($urandom_range(0, 255)),
             LineInW'($urandom_range(0, 65535)), off);
  endtask

  task automatic append_run(input int unsigned n);
    logic [LineInW-1:0] ln;
    ln = pick_line();
    repeat (n) send_append(ByteW'($urandom_range(0, 255)), ln);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned base;
    bit          paused_mid;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    item_count   = 0;
    appends_sent = 0;
    no_idle      = 1'b0;
    last_line    = '0;
    paused_mid   = 1'b0;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, line zero, line extremes, offset at and past the stored code
    send_lookup(OffsetW'(0));
    send_lookup(OffsetW'(StoreDepth - 1));
    send_append(8'h00, 16'h0000);
    send_append(8'hFF, 16'h0000);
    send_lookup(OffsetW'(0));
    send_lookup(OffsetW'(1));
    send_lookup(OffsetW'(2));
    send_append(8'hA5, 16'hFFFF);
    send_append(8'h5A, 16'hFFFF);
    send_append(8'h3C, 16'h0001);
    send_append(8'hC3, 16'h0000);
    send_lookup(OffsetW'(2));
    send_lookup(OffsetW'(3));
    send_lookup(OffsetW'(4));
    send_lookup(OffsetW'(5));
    send_lookup(OffsetW'(6));
    send_append(8'h81, 16'h8000);
    send_lookup(OffsetW'(6));
    send_lookup(OffsetW'(StoreDepth - 1));
    wait_drained();

    // one run pushed past its count limit on the same line
    base = appends_sent;
    no_idle = ($urandom_range(0, 1) == 0);
    last_line = LineInW'($urandom_range(0, 65535));
    repeat (RunLimit + 3) send_append(ByteW'($urandom_range(0, 255)), last_line);
    send_lookup(OffsetW'(base + RunLimit - 1));
    send_lookup(OffsetW'(base + RunLimit));
    send_lookup(OffsetW'(base + RunLimit + 2));
    send_lookup(OffsetW'(base + RunLimit + 3));

    while (item_count < 650) begin
      if (!paused_mid && item_count >= 400) begin
        wait_drained();
        paused_mid = 1'b1;
      end
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 39))
        0: begin
          if (appends_sent < 600) begin
            append_run($urandom_range(200, 300));
          end else begin
            append_run($urandom_range(1, 12));
          end
        end
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20: begin
          append_run($urandom_range(1, 12));
        end
        21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32: send_lookup(pick_offset());
        33, 34, 35: repeat ($urandom_range(2, 5)) send_lookup(pick_offset());
        default: send_append(ByteW'($urandom_range(0, 255)),
                             LineInW'($urandom_range(0, 65535)));
      endcase
    end

    // fill the store, then keep going past full
    while (appends_sent < StoreDepth + 6) begin
      no_idle = ($urandom_range(0, 4) == 0);
      append_run($urandom_range(1, 20));
      if ($urandom_range(0, 3) == 0) begin
        send_lookup(pick_offset());
      end
    end
    repeat (40) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1) == 0) begin
        send_lookup(($urandom_range(0, 3) == 0) ? OffsetW'(StoreDepth - 1) : pick_offset());
      end else begin
        send_append(ByteW'($urandom_range(0, 255)), pick_line());
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("covered %0d appends (%0d dropped on a full store), %0d lookups (%0d not found)",
             sb.append_count, sb.drop_count, sb.lookup_count, sb.miss_count);
    $display("checked %0d responses; %0d bytes in %0d runs, %0d runs closed at count limit",
             sb.checked_count, sb.bytes_used, sb.runs_used, sb.capped_runs);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d responses outstanding", sb.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* code_line_run_table.f */
hw/rtl/clrt_pkg.sv
hw/rtl/code_line_run_table.sv
dv/clrt_sb_pkg.sv
dv/tb_top.sv
